### design/bsd_pkg.sv
package bsd_pkg;

    // pad character of the base64 alphabet
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // end-of-string status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_LENGTH  = 2'd1,
        STATUS_CONTENT = 2'd2
    } status_t;

    // one input request: a text character and the end-of-string flag
    typedef struct packed {
        logic [7:0] char_in;
        logic       final_char;
    } in_item_t;

    // one result: a decoded byte or the status report
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        status_t    status;
        logic       end_of_run;
    } out_item_t;

    // work for the back end: all results caused by one input request
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        logic            has_status;
        status_t         status;
    } job_t;

    // sextet value of a character; bit 6 set when outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            t = c - 8'h41;
            return {1'b0, t[5:0]};
        end
        if (c >= 8'h61 && c <= 8'h7A) begin
            t = c - 8'h47;
            return {1'b0, t[5:0]};
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c + 8'h04;
            return {1'b0, t[5:0]};
        end
        if (c == 8'h2B) begin
            return 7'd62;
        end
        if (c == 8'h2F) begin
            return 7'd63;
        end
        return 7'b100_0000;
    endfunction

endpackage

### design/bsd_front.sv
module bsd_front
    import bsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output logic     job_valid,
    output job_t     job
);

    logic [1:0]      pos_reg, pos_next;
    logic            stopped_reg, stopped_next;
    logic            err_reg, err_next;
    logic [2:0][5:0] held_reg, held_next;

    logic       pad;
    logic [6:0] sx;
    logic [5:0] s;
    logic       bad;
    logic [7:0] b0, b1, b2;

    // classify the character and build the results it causes
    always_comb
    begin
        pad  = (item.char_in == CHAR_PAD);
        sx   = sextet_of(item.char_in);
        s    = sx[5:0];
        bad  = sx[6];
        b0   = {held_reg[0], held_reg[1][5:4]};
        b1   = {held_reg[1][3:0], held_reg[2][5:2]};
        b2   = {held_reg[2][1:0], s};

        pos_next     = pos_reg + 2'd1;
        stopped_next = stopped_reg;
        err_next     = err_reg;
        held_next    = held_reg;

        job            = '0;
        job.bytes[0]   = b0;
        job.bytes[1]   = b1;
        job.bytes[2]   = b2;
        job.nbytes     = 2'd0;
        job.has_status = 1'b0;
        job.status     = STATUS_OK;

        if (!stopped_reg) begin
            if ((pad && pos_reg < 2'd2) || (!pad && bad)) begin
                err_next     = 1'b1;
                stopped_next = 1'b1;
            end else if (pos_reg != 2'd3 && !pad) begin
                case (pos_reg)
                    2'd0:    held_next[0] = s;
                    2'd1:    held_next[1] = s;
                    default: held_next[2] = s;
                endcase
            end else if (pos_reg == 2'd2) begin
                job.nbytes   = 2'd1;
                stopped_next = 1'b1;
            end else if (pad) begin
                job.nbytes   = 2'd2;
                stopped_next = 1'b1;
            end else begin
                job.nbytes = 2'd3;
            end
        end

        // end of string: report status and return to the reset state
        if (item.final_char) begin
            job.has_status = 1'b1;
            if (pos_next != 2'd0) begin
                job.status = STATUS_LENGTH;
            end else if (err_next) begin
                job.status = STATUS_CONTENT;
            end
            pos_next     = 2'd0;
            stopped_next = 1'b0;
            err_next     = 1'b0;
        end

        job_valid = accept && (job.has_status || job.nbytes != 2'd0);
    end

    // group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg     <= 2'd0;
            stopped_reg <= 1'b0;
            err_reg     <= 1'b0;
        end else if (accept) begin
            pos_reg     <= pos_next;
            stopped_reg <= stopped_next;
            err_reg     <= err_next;
        end
    end

    // held sextets, no reset
    always_ff @(posedge clk)
    begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

### design/bsd_job_fifo.sv
module bsd_job_fifo
    import bsd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output job_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    // pointer and count update
    always_comb
    begin
        do_wr       = wr_en && !full;
        do_rd       = rd_en && rd_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    assign full     = (cnt_reg == FULL_CNT);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### design/bsd_back.sv
module bsd_back
    import bsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  job_t      job,
    output logic      job_pop,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    job_t       cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       cur_valid_reg, cur_valid_next;
    out_item_t  out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    logic       slot_free;
    logic       emit;
    logic       last;
    logic [2:0] total;
    out_item_t  item;

    // pick the current result of the job in hand
    always_comb
    begin
        total     = {1'b0, cur_reg.nbytes} + {2'b00, cur_reg.has_status};
        last      = ({1'b0, idx_reg} == total - 3'd1);
        slot_free = !out_valid_reg || pop;
        emit      = cur_valid_reg && slot_free;
        job_pop   = job_valid && (!cur_valid_reg || (emit && last));

        item            = '0;
        item.end_of_run = last;
        item.status     = STATUS_OK;
        if (idx_reg < cur_reg.nbytes) begin
            case (idx_reg)
                2'd0:    item.out_byte = cur_reg.bytes[0];
                2'd1:    item.out_byte = cur_reg.bytes[1];
                default: item.out_byte = cur_reg.bytes[2];
            endcase
        end else begin
            item.is_status = 1'b1;
            item.status    = cur_reg.status;
        end
    end

    // job register and output register
    always_comb
    begin
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        cur_valid_next = cur_valid_reg;
        if (job_pop) begin
            cur_next       = job;
            idx_next       = 2'd0;
            cur_valid_next = 1'b1;
        end else if (emit && last) begin
            cur_valid_next = 1'b0;
        end else if (emit) begin
            idx_next = idx_reg + 2'd1;
        end

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_next       = item;
            out_valid_next = 1'b1;
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule

### design/base64_stream_decoder_unit.sv
// Streaming base64 decoder, standard alphabet, one character per request.
// Input channel: push / full with item (char_in, final_char); a request is
// taken when push is high and full is low. Result channel: empty / pop with
// result (out_byte, is_status, status, end_of_run); the head result is shown
// while empty is low and leaves when pop is high.
// Each completed group of four gives up to three bytes; the final character
// is followed by a status result (0 ok, 1 bad length, 2 bad content).
// end_of_run marks the last result caused by one request. Bytes of a string
// whose status is nonzero are to be dropped by the receiver.
// Throughput: one request per cycle while the job queue has room; the
// result side moves one result per cycle while the output register is free,
// so a request giving n results holds the back end until all n have left.
// Results pass through the job queue, the job register and the output register.
// When the receiver stalls, the output register holds, the back end waits,
// the JOB_DEPTH entry queue fills and full rises to stall the sender.
// Reset clears group state, the queue and the output valid; the block takes
// requests as soon as reset is released.
module base64_stream_decoder_unit
    import bsd_pkg::*;
#(
    parameter int JOB_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic accept;
    logic fe_valid;
    job_t fe_job;
    logic q_valid;
    job_t q_job;
    logic q_pop;

    assign accept = push && !full;

    // front end: classify characters, keep group state
    bsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .job_valid (fe_valid),
        .job       (fe_job)
    );

    // queue of pending jobs between the two ends
    bsd_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fe_valid),
        .wr_data  (fe_job),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_job)
    );

    // back end: one result per cycle into the output register while it is free
    bsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_job),
        .job_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

### design/bsd_checker.sv
module bsd_checker
    import bsd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input in_item_t  item,
    input logic      empty,
    input logic      pop,
    input out_item_t result
);

    // a status report always closes the run of its request
    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.is_status) |-> result.end_of_run)
        else $error("status result without end_of_run");

    // byte results carry a zero status
    a_byte_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.is_status) |-> (result.status == STATUS_OK))
        else $error("byte result with nonzero status");

    // status results carry a zero byte and a defined code
    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.is_status) |->
            (result.out_byte == 8'h00 && result.status != 2'd3))
        else $error("malformed status result");

    // a waiting result holds until popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

endmodule

bind base64_stream_decoder_unit bsd_checker u_bsd_checker (.*);
